// ----- src/kli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Shared constants, request and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kli_pkg;

    // Default sizing of the key table and of the vector components.
    localparam int DEF_MAX_KEYS   = 256;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths.
    localparam int TIME_BITS  = 32;
    localparam int SLOT_BITS  = 8;
    localparam int SEG_BITS   = 8;
    localparam int COUNT_BITS = 9;
    localparam int FRAC_BITS  = 16;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_BEFORE = 2'd2;
    localparam logic [1:0] ST_AFTER  = 2'd3;

    // Key memory address sources.
    localparam logic [1:0] ADDR_SLOT = 2'd0;
    localparam logic [1:0] ADDR_SRCH = 2'd1;
    localparam logic [1:0] ADDR_SEG  = 2'd2;
    localparam logic [1:0] ADDR_ZERO = 2'd3;

    // Vector component selects.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       mem_we;
        logic       mem_re;
        logic [1:0] addr_sel;
        logic       q_capture;
        logic       srch_step;
        logic       hi_capture;
        logic       div_start;
        logic       lerp_diff;
        logic       lerp_mul;
        logic       lerp_add;
        logic [1:0] comp;
        logic       out_load;
        logic [1:0] out_status;
    } kli_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_one;
        logic srch_hit;
        logic srch_last;
        logic before_first;
        logic div_done;
        logic out_free;
    } kli_stat_t;

endpackage

// ----- src/kli_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpolation factor divider
// Restoring divider producing floor((num << FRAC_BITS) / den), one quotient
// bit per cycle. The numerator must be below the denominator.
// ----------------------------------------------------------------------------
module kli_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [kli_pkg::TIME_BITS-1:0]  num,
    input  logic [kli_pkg::TIME_BITS-1:0]  den,
    output logic                           done,
    output logic [kli_pkg::FRAC_BITS-1:0]  quo
);
    import kli_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic [FRAC_BITS-1:0] quo_reg;

    logic [TIME_BITS:0]   rem_sh;
    logic                 ge;
    logic [TIME_BITS:0]   rem_sub;
    logic [TIME_BITS-1:0] rem_next;

    // One shift-and-subtract step; the remainder stays below the divisor.
    always_comb
    begin
        rem_sh   = {rem_reg, 1'b0};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_sub  = rem_sh - {1'b0, den_reg};
        rem_next = ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- src/kli_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator datapath
// Key memory, key count register, search counters, factor divider, the
// shared lerp multiplier and the output register.
// ----------------------------------------------------------------------------
module kli_datapath #(
    parameter int MAX_KEYS   = kli_pkg::DEF_MAX_KEYS,
    parameter int VALUE_BITS = kli_pkg::DEF_VALUE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kli_pkg::kli_cmd_t               cmd,
    output kli_pkg::kli_stat_t              stat,
    input  logic [kli_pkg::SLOT_BITS-1:0]   key_slot,
    input  logic [kli_pkg::TIME_BITS-1:0]   key_time,
    input  logic [VALUE_BITS-1:0]           key_x,
    input  logic [VALUE_BITS-1:0]           key_y,
    input  logic [VALUE_BITS-1:0]           key_z,
    input  logic [kli_pkg::TIME_BITS-1:0]   query_time,
    input  logic                            cfg_we,
    input  logic [kli_pkg::COUNT_BITS-1:0]  cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [VALUE_BITS-1:0]           out_x,
    output logic [VALUE_BITS-1:0]           out_y,
    output logic [VALUE_BITS-1:0]           out_z,
    output logic [kli_pkg::SEG_BITS-1:0]    out_seg,
    output logic [1:0]                      out_status
);
    import kli_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int IDX_W  = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
    localparam int SEG_W  = (IDX_W > SEG_BITS) ? IDX_W : SEG_BITS;
    localparam int WORD_W = TIME_BITS + 3 * VB;
    localparam int PROD_W = VB + FRAC_BITS + 2;

    // Key memory: one word per key, {time, z, y, x}.
    logic [WORD_W-1:0]     mem [MAX_KEYS];
    logic [WORD_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]      addr;
    logic [CMP_W-1:0]      slot_w;
    logic                  slot_ok;

    logic [COUNT_BITS-1:0] key_count_reg;
    logic [CMP_W-1:0]      kc_w;
    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      n_reg;
    logic [TIME_BITS-1:0]  q_reg;
    logic [CNT_W-1:0]      rd_idx_reg;
    logic [CNT_W-1:0]      cmp_idx_reg;
    logic [CNT_W-1:0]      cmp_prev;
    logic [IDX_W-1:0]      seg_reg;
    logic [WORD_W-1:0]     hi_reg;

    logic [TIME_BITS-1:0]  rd_time;
    logic [TIME_BITS-1:0]  hi_time;
    logic [TIME_BITS-1:0]  div_num;
    logic [TIME_BITS-1:0]  div_den;
    logic                  div_done;
    logic [FRAC_BITS-1:0]  factor;

    logic [VB-1:0]         start_val;
    logic [VB-1:0]         end_val;
    logic signed [VB:0]    d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VB-1:0]         lerp_sum;
    logic [VB-1:0]         res_x_reg;
    logic [VB-1:0]         res_y_reg;
    logic [VB-1:0]         res_z_reg;

    logic                  m_valid_reg;
    logic [VB-1:0]         m_x_reg;
    logic [VB-1:0]         m_y_reg;
    logic [VB-1:0]         m_z_reg;
    logic [SEG_W-1:0]      seg_w;
    logic [SEG_BITS-1:0]   m_seg_reg;
    logic [1:0]            m_status_reg;

    // Load slot range check and effective key count.
    always_comb
    begin
        slot_w  = CMP_W'(key_slot);
        slot_ok = (slot_w < CMP_W'(MAX_KEYS));
        kc_w    = CMP_W'(key_count_reg);
        if (kc_w == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (kc_w > CMP_W'(MAX_KEYS))
        begin
            n_eff = CNT_W'(MAX_KEYS);
        end
        else
        begin
            n_eff = kc_w[CNT_W-1:0];
        end
    end

    // Memory address selection.
    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_SLOT: addr = slot_w[IDX_W-1:0];
            ADDR_SRCH: addr = rd_idx_reg[IDX_W-1:0];
            ADDR_SEG:  addr = seg_reg;
            ADDR_ZERO: addr = '0;
            default:   addr = '0;
        endcase
    end

    // Single-port key memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we && slot_ok)
        begin
            mem[addr] <= {key_time, key_z, key_y, key_x};
        end
        if (cmd.mem_re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Key count configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= COUNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_data;
        end
    end

    // Query capture, search counters and segment bookkeeping.
    assign cmp_prev = cmp_idx_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            seg_reg     <= '0;
            n_reg       <= '0;
        end
        else
        begin
            if (cmd.q_capture)
            begin
                n_reg      <= n_eff;
                rd_idx_reg <= CNT_W'(1);
                seg_reg    <= '0;
            end
            else if (cmd.srch_step)
            begin
                cmp_idx_reg <= rd_idx_reg;
                rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
            end
            if (cmd.hi_capture)
            begin
                seg_reg <= cmp_prev[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_capture)
        begin
            q_reg <= query_time;
        end
        if (cmd.hi_capture)
        begin
            hi_reg <= rd_data_reg;
        end
    end

    // Comparisons reported to the controller.
    assign rd_time = rd_data_reg[WORD_W-1 -: TIME_BITS];
    assign hi_time = hi_reg[WORD_W-1 -: TIME_BITS];

    assign stat.n_one        = (n_eff == CNT_W'(1));
    assign stat.srch_hit     = (q_reg < rd_time);
    assign stat.srch_last    = (cmp_idx_reg == (n_reg - CNT_W'(1)));
    assign stat.before_first = (q_reg < rd_time);
    assign stat.div_done     = div_done;
    assign stat.out_free     = !m_valid_reg || out_ready;

    // Interpolation factor: (t - t0) / (t1 - t0) in Q0.16.
    assign div_num = q_reg - rd_time;
    assign div_den = hi_time - rd_time;

    kli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (factor)
    );

    // Component selection for the shared lerp unit.
    always_comb
    begin
        case (cmd.comp)
            COMP_X:
            begin
                start_val = rd_data_reg[0 +: VB];
                end_val   = hi_reg[0 +: VB];
            end
            COMP_Y:
            begin
                start_val = rd_data_reg[VB +: VB];
                end_val   = hi_reg[VB +: VB];
            end
            default:
            begin
                start_val = rd_data_reg[2*VB +: VB];
                end_val   = hi_reg[2*VB +: VB];
            end
        endcase
    end

    // start + floor(factor * (end - start) / 2^16): difference, product, sum.
    assign lerp_sum = start_val + prod_reg[VB+FRAC_BITS-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_diff)
        begin
            d_reg <= signed'({end_val[VB-1], end_val}) - signed'({start_val[VB-1], start_val});
        end
        if (cmd.lerp_mul)
        begin
            prod_reg <= PROD_W'(signed'({1'b0, factor})) * PROD_W'(d_reg);
        end
        if (cmd.lerp_add)
        begin
            case (cmd.comp)
                COMP_X:  res_x_reg <= lerp_sum;
                COMP_Y:  res_y_reg <= lerp_sum;
                default: res_z_reg <= lerp_sum;
            endcase
        end
    end

    // Output register.
    assign seg_w = SEG_W'(seg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_seg_reg    <= seg_w[SEG_BITS-1:0];
            m_status_reg <= cmd.out_status;
            case (cmd.out_status) inside
                ST_INTERP:
                begin
                    m_x_reg <= res_x_reg;
                    m_y_reg <= res_y_reg;
                    m_z_reg <= res_z_reg;
                end
                ST_SINGLE, ST_BEFORE:
                begin
                    m_x_reg <= rd_data_reg[0 +: VB];
                    m_y_reg <= rd_data_reg[VB +: VB];
                    m_z_reg <= rd_data_reg[2*VB +: VB];
                end
                default:
                begin
                    m_x_reg <= hi_reg[0 +: VB];
                    m_y_reg <= hi_reg[VB +: VB];
                    m_z_reg <= hi_reg[2*VB +: VB];
                end
            endcase
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_x      = m_x_reg;
    assign out_y      = m_y_reg;
    assign out_z      = m_z_reg;
    assign out_seg    = m_seg_reg;
    assign out_status = m_status_reg;

endmodule

// ----- src/kli_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator controller
// Sequences one item at a time: writes a load as it is accepted, and runs an
// interpolated query through search, divide, three lerp passes and handoff.
// ----------------------------------------------------------------------------
module kli_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                req_type,
    output logic                in_ready,
    input  kli_pkg::kli_stat_t  stat,
    output kli_pkg::kli_cmd_t   cmd
);
    import kli_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SINGLE_RD = 4'd1;
    localparam logic [3:0] S_SRCH_1ST  = 4'd2;
    localparam logic [3:0] S_SRCH      = 4'd3;
    localparam logic [3:0] S_SEG_RD    = 4'd4;
    localparam logic [3:0] S_CHECK     = 4'd5;
    localparam logic [3:0] S_DIV       = 4'd6;
    localparam logic [3:0] S_LDIFF     = 4'd7;
    localparam logic [3:0] S_LMUL      = 4'd8;
    localparam logic [3:0] S_LADD      = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] comp_reg;
    logic [1:0] comp_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.addr_sel   = ADDR_SRCH;
        cmd.comp       = comp_reg;
        cmd.out_status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.addr_sel = ADDR_SLOT;
                if (accept)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.mem_we = 1'b1;
                    end
                    else
                    begin
                        cmd.q_capture = 1'b1;
                        state_next    = stat.n_one ? S_SINGLE_RD : S_SRCH_1ST;
                    end
                end
            end
            S_SINGLE_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_ZERO;
                status_next  = ST_SINGLE;
                state_next   = S_OUT;
            end
            S_SRCH_1ST:
            begin
                cmd.mem_re    = 1'b1;
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH;
            end
            S_SRCH:
            begin
                if (stat.srch_hit)
                begin
                    cmd.hi_capture = 1'b1;
                    state_next     = S_SEG_RD;
                end
                else if (stat.srch_last)
                begin
                    cmd.hi_capture = 1'b1;
                    status_next    = ST_AFTER;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.mem_re    = 1'b1;
                    cmd.srch_step = 1'b1;
                end
            end
            S_SEG_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_SEG;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.before_first)
                begin
                    status_next = ST_BEFORE;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    comp_next  = COMP_X;
                    state_next = S_LDIFF;
                end
            end
            S_LDIFF:
            begin
                cmd.lerp_diff = 1'b1;
                state_next    = S_LMUL;
            end
            S_LMUL:
            begin
                cmd.lerp_mul = 1'b1;
                state_next   = S_LADD;
            end
            S_LADD:
            begin
                cmd.lerp_add = 1'b1;
                if (comp_reg == COMP_Z)
                begin
                    status_next = ST_INTERP;
                    state_next  = S_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_LDIFF;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            comp_reg   <= COMP_X;
            status_reg <= ST_INTERP;
        end
        else
        begin
            state_reg  <= state_next;
            comp_reg   <= comp_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- src/keyframe_linear_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keeps a table of keyframes (time plus x, y, z) and answers time queries
// with the linearly interpolated vector between the surrounding keys.
//
// Channel   Direction  Handshake           Item
// s_*       in         s_tvalid/s_tready   key load or time query
// m_*       out        m_tvalid/m_tready   interpolated vector, segment, status
// cfg_*     in         cfg_valid/cfg_ready key count register write
//
// A load is written as it is accepted, and a query with one key in use returns
// key 0. An interpolated query reads one key per cycle from the single-port key
// memory in its search, the divider takes one quotient bit per cycle, and a
// single multiplier serves x, y and z in turn. A query before the first key, or
// at or past the last of n keys, is clamped to that key. Reset clears the
// control state and sets the key count to 1; the key memory is not cleared. A
// finished result waits in the output register while the next item is taken
// in; a query that finishes while it still waits is held.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS   = kli_pkg::DEF_MAX_KEYS,
    parameter int VALUE_BITS = kli_pkg::DEF_VALUE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // key_slot, key_time, key_x, key_y, key_z, query_time (lowest first)
    input  logic [((72 + 3 * VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_x, out_y, out_z, segment (lowest first)
    output logic [((8 + 3 * VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [kli_pkg::COUNT_BITS-1:0]         cfg_data
);
    import kli_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int OUT_DW = ((8 + 3 * VALUE_BITS + 7) / 8) * 8;
    localparam int OFS_T  = SLOT_BITS;
    localparam int OFS_X  = OFS_T + TIME_BITS;
    localparam int OFS_Q  = OFS_X + 3 * VB;

    kli_cmd_t            cmd;
    kli_stat_t           stat;
    logic [VB-1:0]       out_x;
    logic [VB-1:0]       out_y;
    logic [VB-1:0]       out_z;
    logic [SEG_BITS-1:0] out_seg;

    // Register port always free; the user must write only while idle (unchecked).
    assign cfg_ready = 1'b1;

    kli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .req_type (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kli_datapath #(
        .MAX_KEYS   (MAX_KEYS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .key_slot   (s_tdata[SLOT_BITS-1:0]),
        .key_time   (s_tdata[OFS_T +: TIME_BITS]),
        .key_x      (s_tdata[OFS_X +: VB]),
        .key_y      (s_tdata[OFS_X + VB +: VB]),
        .key_z      (s_tdata[OFS_X + 2 * VB +: VB]),
        .query_time (s_tdata[OFS_Q +: TIME_BITS]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_seg    (out_seg),
        .out_status (m_tuser)
    );

    // Result packing, padded with zeros to whole bytes.
    assign m_tdata = OUT_DW'({out_seg, out_z, out_y, out_x});

endmodule
